FILE: hdl/lab_pkg.sv
`timescale 1ns / 1ps

package lab_pkg;

	localparam logic [2:0] MODE_PULSE   = 3'd0;
	localparam logic [2:0] MODE_BREATHE = 3'd1;
	localparam logic [2:0] MODE_BLINK   = 3'd2;
	localparam logic [2:0] MODE_SNOW    = 3'd3;
	localparam logic [2:0] MODE_PSNOW   = 3'd4;
	localparam logic [2:0] MODE_SLIDE   = 3'd5;

	localparam logic [31:0] TRI_PERIOD  = 32'd3000;
	localparam logic [31:0] SNOW_CYCLE  = 32'd2000;
	localparam logic [31:0] SLIDE_CYCLE = 32'd5000;
	localparam logic [10:0] TRI_HALF    = 11'd1500;
	localparam int unsigned BLINK_BIT   = 10;
	localparam logic [19:0] BLINK_SET   = 20'h4EAAA;
	localparam logic [4:0]  LED_COUNT   = 5'd20;

	// floor(2^32 / N): quotient estimate is exact or one low
	localparam logic [63:0] RCP_TRI   = (64'd1 << 32) / 64'd3000;
	localparam logic [63:0] RCP_SNOW  = (64'd1 << 32) / 64'd2000;
	localparam logic [63:0] RCP_SLIDE = (64'd1 << 32) / 64'd5000;
	localparam int unsigned QW_TRI   = 21;
	localparam int unsigned QW_SNOW  = 22;
	localparam int unsigned QW_SLIDE = 20;

	// x / 200 as (x * 5243) >> 20, exact for x < 5000
	localparam logic [12:0] RCP_SLOT = 13'd5243;
	// x / 15 as (x * 69906) >> 20, exact for x <= 1500
	localparam logic [16:0] RCP_PCT  = 17'd69906;
	// x / 100 as (x * 10737419) >> 30, exact for x < 2^23
	localparam logic [23:0] RCP_HUND = 24'd10737419;

	typedef struct packed {
		logic [2:0] mode;
		logic       blink_lit;
		logic [2:0] layer;
		logic [4:0] pos;
	} side_t;

	function automatic logic [2:0] snow_layer(input logic [4:0] led);
		logic [2:0] r;
		unique case (led)
			5'd0:    r = 3'd3;
			5'd1:    r = 3'd2;
			5'd2:    r = 3'd1;
			5'd3:    r = 3'd0;
			5'd4:    r = 3'd0;
			5'd5:    r = 3'd0;
			5'd6:    r = 3'd1;
			5'd7:    r = 3'd2;
			5'd8:    r = 3'd4;
			5'd9:    r = 3'd3;
			5'd10:   r = 3'd2;
			5'd11:   r = 3'd1;
			5'd12:   r = 3'd0;
			5'd13:   r = 3'd4;
			5'd14:   r = 3'd4;
			5'd15:   r = 3'd3;
			5'd16:   r = 3'd4;
			5'd17:   r = 3'd2;
			5'd18:   r = 3'd1;
			5'd19:   r = 3'd3;
			default: r = 3'd4;
		endcase
		return r;
	endfunction

	function automatic logic [4:0] slide_pos(input logic [4:0] led);
		logic [4:0] r;
		unique case (led)
			5'd0:    r = 5'd12;
			5'd1:    r = 5'd8;
			5'd2:    r = 5'd4;
			5'd3:    r = 5'd0;
			5'd4:    r = 5'd2;
			5'd5:    r = 5'd1;
			5'd6:    r = 5'd5;
			5'd7:    r = 5'd9;
			5'd8:    r = 5'd19;
			5'd9:    r = 5'd15;
			5'd10:   r = 5'd11;
			5'd11:   r = 5'd7;
			5'd12:   r = 5'd3;
			5'd13:   r = 5'd17;
			5'd14:   r = 5'd16;
			5'd15:   r = 5'd14;
			5'd16:   r = 5'd18;
			5'd17:   r = 5'd10;
			5'd18:   r = 5'd6;
			5'd19:   r = 5'd13;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/lab_residue.sv
`timescale 1ns / 1ps

module lab_residue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_vld,
	input  logic [31:0]     src_t,
	input  lab_pkg::side_t  src_side,
	output logic            res_vld,
	output lab_pkg::side_t  res_side,
	output logic [11:0]     tri_mod,
	output logic [10:0]     snow_mod,
	output logic [12:0]     slide_mod
);
	import lab_pkg::*;

	logic [63:0]          prod_tri, prod_snow, prod_slide;
	logic [QW_TRI-1:0]    q_tri_s2;
	logic [QW_SNOW-1:0]   q_snow_s2;
	logic [QW_SLIDE-1:0]  q_slide_s2;
	logic [31:0]          t_s2, t_s3;
	side_t                side_s2, side_s3, side_s4;
	logic                 vld_s2, vld_s3, vld_s4;
	logic [31:0]          qn_tri_s3, qn_snow_s3, qn_slide_s3;
	logic [31:0]          d_tri, d_snow, d_slide;
	logic [12:0]          dn_tri;
	logic [11:0]          dn_snow;
	logic [13:0]          dn_slide;
	logic [11:0]          m_tri_s4;
	logic [10:0]          m_snow_s4;
	logic [12:0]          m_slide_s4;

	assign prod_tri   = 64'(src_t) * RCP_TRI;
	assign prod_snow  = 64'(src_t) * RCP_SNOW;
	assign prod_slide = 64'(src_t) * RCP_SLIDE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s2 <= src_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// quotient estimate
	always_ff @(posedge clk) begin
		q_tri_s2   <= prod_tri[32 +: QW_TRI];
		q_snow_s2  <= prod_snow[32 +: QW_SNOW];
		q_slide_s2 <= prod_slide[32 +: QW_SLIDE];
		t_s2       <= src_t;
		side_s2    <= src_side;
	end

	// quotient times modulus
	always_ff @(posedge clk) begin
		qn_tri_s3   <= 32'(64'(q_tri_s2) * 64'(TRI_PERIOD));
		qn_snow_s3  <= 32'(64'(q_snow_s2) * 64'(SNOW_CYCLE));
		qn_slide_s3 <= 32'(64'(q_slide_s2) * 64'(SLIDE_CYCLE));
		t_s3        <= t_s2;
		side_s3     <= side_s2;
	end

	// remainder below twice the modulus, one correction
	assign d_tri    = t_s3 - qn_tri_s3;
	assign d_snow   = t_s3 - qn_snow_s3;
	assign d_slide  = t_s3 - qn_slide_s3;
	assign dn_tri   = d_tri[12:0];
	assign dn_snow  = d_snow[11:0];
	assign dn_slide = d_slide[13:0];

	always_ff @(posedge clk) begin
		m_tri_s4   <= (dn_tri >= 13'(TRI_PERIOD)) ? 12'(dn_tri - 13'(TRI_PERIOD))
			: dn_tri[11:0];
		m_snow_s4  <= (dn_snow >= 12'(SNOW_CYCLE)) ? 11'(dn_snow - 12'(SNOW_CYCLE))
			: dn_snow[10:0];
		m_slide_s4 <= (dn_slide >= 14'(SLIDE_CYCLE)) ? 13'(dn_slide - 14'(SLIDE_CYCLE))
			: dn_slide[12:0];
		side_s4    <= side_s3;
	end

	assign res_vld   = vld_s4;
	assign res_side  = side_s4;
	assign tri_mod   = m_tri_s4;
	assign snow_mod  = m_snow_s4;
	assign slide_mod = m_slide_s4;

endmodule

FILE: hdl/led_animation_brightness_top.sv
`timescale 1ns / 1ps

// LED animation brightness.
// Command channel: present time_ms, led_index and phase_ms with start high;
// the beat is taken at any rising edge where busy is low. busy never rises,
// so one beat can be taken every cycle.
// Result channel: brightness is shown for exactly one cycle with done high,
// once the command has passed the eight register stages, in command order.
// The receiver has no way to hold results off and must take every beat.
// The eight register stages are: operand/table lookup,
// three stages of constant-modulus reduction (reciprocal multiply, back
// multiply, subtract and correct), slot and triangle distance, percent
// scaling, level multiply, and the divide by one hundred.
// Config: cfg_data carries the mode, written when cfg_valid and cfg_ready
// are both high; cfg_ready is always high. Change mode only while idle.
// Reset: arst_n low clears the pipeline valid bits and sets mode to pulse;
// nothing is in flight afterwards and no memory needs clearing.
module led_animation_brightness_top #(
	parameter int unsigned MAX_LEVEL = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] time_ms,
	input  logic [4:0]  led_index,
	input  logic [11:0] phase_ms,
	output logic        done,
	output logic [15:0] brightness,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	import lab_pkg::*;

	localparam logic [15:0] MAX16 = 16'(MAX_LEVEL);

	logic [2:0]  mode_q;
	logic        accept;
	logic        known;
	logic        inv;

	logic        vld_s1;
	logic [31:0] t_s1;
	side_t       side_s1;

	logic        vld_s4;
	side_t       side_s4;
	logic [11:0] m_tri_s4;
	logic [10:0] m_snow_s4;
	logic [12:0] m_slide_s4;

	logic [10:0] tri_dist;
	logic [23:0] snow_prod;
	logic [24:0] slide_prod;

	logic        vld_s5;
	side_t       side_s5;
	logic [10:0] rem_s5;
	logic [3:0]  snow_slot_s5;
	logic [4:0]  slide_slot_s5;

	logic [27:0] pct_prod;
	logic        lit;
	logic        vld_s6, lit_s6, tri_s6;
	logic [6:0]  pct_s6;

	logic        vld_s7, lit_s7, tri_s7;
	logic [22:0] lvl_s7;

	logic [46:0] hund_prod;
	logic        vld_s8, tri_s8;
	logic [15:0] bright_s8;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PULSE;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign known = led_index < LED_COUNT;
	assign inv   = known && BLINK_SET[led_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		t_s1 <= (mode_q == MODE_BREATHE) ? (time_ms + 32'(phase_ms)) : time_ms;
		side_s1.mode      <= mode_q;
		side_s1.blink_lit <= time_ms[BLINK_BIT] ^ inv;
		side_s1.layer     <= snow_layer(led_index);
		side_s1.pos       <= slide_pos(led_index);
	end

	lab_residue u_residue (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_vld   (vld_s1),
		.src_t     (t_s1),
		.src_side  (side_s1),
		.res_vld   (vld_s4),
		.res_side  (side_s4),
		.tri_mod   (m_tri_s4),
		.snow_mod  (m_snow_s4),
		.slide_mod (m_slide_s4)
	);

	// triangle distance and time slots
	assign tri_dist = (m_tri_s4 >= 12'(TRI_HALF)) ? 11'(m_tri_s4 - 12'(TRI_HALF))
		: 11'(12'(TRI_HALF) - m_tri_s4);
	assign snow_prod  = 24'(m_snow_s4) * 24'(RCP_SLOT);
	assign slide_prod = 25'(m_slide_s4) * 25'(RCP_SLOT);

	always_ff @(posedge clk) begin
		rem_s5        <= TRI_HALF - tri_dist;
		snow_slot_s5  <= snow_prod[23:20];
		slide_slot_s5 <= slide_prod[24:20];
		side_s5       <= side_s4;
	end

	assign pct_prod = 28'(rem_s5) * 28'(RCP_PCT);

	always_comb begin
		unique case (side_s5.mode)
			MODE_BLINK: lit = side_s5.blink_lit;
			MODE_SNOW:  lit = (4'(side_s5.layer) == snow_slot_s5);
			MODE_PSNOW: lit = (4'(side_s5.layer) <= snow_slot_s5);
			MODE_SLIDE: lit = (side_s5.pos <= slide_slot_s5);
			default:    lit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		pct_s6 <= pct_prod[26:20];
		lit_s6 <= lit;
		tri_s6 <= (side_s5.mode == MODE_PULSE) || (side_s5.mode == MODE_BREATHE);
	end

	always_ff @(posedge clk) begin
		lvl_s7 <= 23'(MAX16) * 23'(pct_s6);
		lit_s7 <= lit_s6;
		tri_s7 <= tri_s6;
	end

	assign hund_prod = 47'(lvl_s7) * 47'(RCP_HUND);

	always_ff @(posedge clk) begin
		tri_s8 <= tri_s7;
		if (tri_s7) begin
			bright_s8 <= hund_prod[45:30];
		end else begin
			bright_s8 <= lit_s7 ? MAX16 : 16'd0;
		end
	end

	assign done       = vld_s8;
	assign brightness = bright_s8;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 8))
		else $error("result beat without a command eight cycles earlier");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (brightness <= MAX16))
		else $error("brightness above maximum level");

	a_onoff: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !tri_s8) |-> ((brightness == 16'd0) || (brightness == MAX16)))
		else $error("on/off pattern gave an intermediate level");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> $past(vld_s1, 4))
		else $error("reduction pipeline valid out of step");
`endif

endmodule
